[src/agss_pkg.sv]
// Shared types, codes and the step table contents of the agitate/soak step sequencer.
package agss_pkg;

    // Width of one step table entry: two kind bits over a 16-bit duration.
    localparam int STEP_ENTRY_W = 18;

    // Step durations in milliseconds.
    localparam logic [15:0] DUR_SOAK_FIRST  = 16'd1000;
    localparam logic [15:0] DUR_AGIT_FIRST  = 16'd500;
    localparam logic [15:0] DUR_SOAK_SECOND = 16'd1000;
    localparam logic [15:0] DUR_AGIT_SECOND = 16'd1500;
    localparam logic [15:0] DUR_SET_END     = 16'd200;
    localparam logic [15:0] DUR_NONE        = 16'd0;

    // Item opcodes; the fourth code is ignored.
    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_START  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_PROGRAM_SELECT = 1'b0,
        CFG_START_SET      = 1'b1
    } cfg_reg_t;

    // Sequencer phases as they appear on the phase output.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_INIT    = 4'd1,
        PH_START   = 4'd2,
        PH_FILL    = 4'd3,
        PH_ACTUATE = 4'd4,
        PH_RUN     = 4'd5,
        PH_STOP    = 4'd6,
        PH_END     = 4'd7,
        PH_DEINIT  = 4'd8
    } phase_t;

    // Step kinds stored in the table; the fourth code does nothing.
    typedef enum logic [1:0] {
        KIND_AGIT = 2'd0,
        KIND_SOAK = 2'd1,
        KIND_END  = 2'd2
    } step_kind_t;

    // Table entry for a step position; every program and set uses the same steps.
    function automatic logic [STEP_ENTRY_W-1:0] step_entry(input logic [4:0] k);
        logic [STEP_ENTRY_W-1:0] e;
        case (k)
            5'd0:    e = {KIND_SOAK, DUR_SOAK_FIRST};
            5'd1:    e = {KIND_AGIT, DUR_AGIT_FIRST};
            5'd2:    e = {KIND_SOAK, DUR_SOAK_SECOND};
            5'd3:    e = {KIND_AGIT, DUR_AGIT_SECOND};
            5'd4:    e = {KIND_END, DUR_SET_END};
            default: e = {KIND_END, DUR_NONE};
        endcase
        return e;
    endfunction

endpackage

[src/agitate_soak_step_sequencer.sv]
// Top level of the agitate/soak step sequencer: input register, step logic and result state.
//
// Usage: each input word (opcode, now_ms, door_open) enters on the in channel and
// produces exactly one result word on the out channel: the motor latches, phase,
// step and set indices and the finished flag as they stand after that word.
// A word passes through an input register, then the step logic updates the
// sequencer state, which drives the result ports directly.
// A word accepted into the input register has its result registered with out_valid;
// while the receiver does not stall, one word is accepted every cycle, since the whole step
// update (one table read, one 32-bit elapsed-time subtract and compare, one phase
// decode) sits between the input register and the state registers.
// When the receiver stalls, the result and all state hold and the input register
// keeps its word; in_stall rises only once the input register is full as well.
// Reset clears the phase to idle, the indices, the timer and both motor latches,
// and the configuration registers to zero. Configuration writes take effect on
// the next start word; the user must make them while the block is idle (the block does not enforce it).
module agitate_soak_step_sequencer
    import agss_pkg::*;
#(
    parameter int NUM_PROGRAMS = 2,
    parameter int NUM_SETS     = 3,
    parameter int NUM_STEPS    = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic        door_open,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        motor_ccw,
    output logic        motor_cw,
    output logic [3:0]  phase,
    output logic [3:0]  step_number,
    output logic [1:0]  set_number,
    output logic        finished
);

    localparam int PW       = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
    localparam int SETW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SW       = $clog2(NUM_STEPS + 1);
    localparam int ROM_SIZE = NUM_PROGRAMS * NUM_SETS * NUM_STEPS;
    localparam int AW       = (ROM_SIZE > 1) ? $clog2(ROM_SIZE) : 1;

    // Configuration registers.
    logic            program_select_reg;
    logic [1:0]      start_set_reg;

    // Input register.
    logic            s1_valid_reg, s1_valid_next;
    logic [1:0]      s1_opcode_reg;
    logic [31:0]     s1_now_reg;
    logic            s1_door_reg;
    logic            s1_move;

    // Sequencer state.
    logic            out_valid_reg, out_valid_next;
    phase_t          phase_reg, phase_next;
    logic [SW-1:0]   step_idx_reg, step_idx_next;
    logic [SETW-1:0] set_idx_reg, set_idx_next;
    logic [PW-1:0]   program_idx_reg, program_idx_next;
    logic [31:0]     start_time_reg, start_time_next;
    logic            ccw_latch_reg, ccw_latch_next;
    logic            cw_latch_reg, cw_latch_next;

    // Step table and its read path.
    logic [STEP_ENTRY_W-1:0] step_rom [ROM_SIZE];
    logic                    step_in_range;
    logic [SW-1:0]           rom_step;
    logic [AW-1:0]           rom_addr;
    logic [STEP_ENTRY_W-1:0] rom_word;
    step_kind_t              step_kind;
    logic [15:0]             step_dur;
    logic [31:0]             elapsed;
    logic                    step_done;

    // Constant step table, one entry per program, set and step.
    for (genvar g = 0; g < ROM_SIZE; g++)
    begin : g_rom
        assign step_rom[g] = step_entry(5'(g % NUM_STEPS));
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_select_reg <= 1'b0;
            start_set_reg      <= 2'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PROGRAM_SELECT: program_select_reg <= cfg_data[0];
                CFG_START_SET:      start_set_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result slot frees.
    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_opcode_reg <= opcode;
            s1_now_reg    <= now_ms;
            s1_door_reg   <= door_open;
        end
    end

    // Step table read and elapsed-time compare for the current step.
    always_comb
    begin
        step_in_range = int'(step_idx_reg) < NUM_STEPS;
        rom_step      = step_in_range ? step_idx_reg : '0;
        rom_addr      = AW'((int'(program_idx_reg) * NUM_SETS + int'(set_idx_reg))
                            * NUM_STEPS + int'(rom_step));
        rom_word      = step_rom[rom_addr];
        step_kind     = step_in_range ? step_kind_t'(rom_word[17:16]) : KIND_END;
        step_dur      = step_in_range ? rom_word[15:0] : DUR_NONE;
        elapsed       = s1_now_reg - start_time_reg;
        step_done     = elapsed >= {16'd0, step_dur};
    end

    // Next sequencer state for the word in the input register.
    always_comb
    begin
        phase_t ph;
        phase_next       = phase_reg;
        step_idx_next    = step_idx_reg;
        set_idx_next     = set_idx_reg;
        program_idx_next = program_idx_reg;
        start_time_next  = start_time_reg;
        ccw_latch_next   = ccw_latch_reg;
        cw_latch_next    = cw_latch_reg;
        ph               = s1_door_reg ? PH_STOP : phase_reg;

        case (op_t'(s1_opcode_reg))
            OP_START:
            begin
                program_idx_next = (int'(program_select_reg) < NUM_PROGRAMS)
                                   ? PW'(program_select_reg) : PW'(NUM_PROGRAMS - 1);
                set_idx_next     = (int'(start_set_reg) < NUM_SETS)
                                   ? SETW'(start_set_reg) : SETW'(NUM_SETS - 1);
                phase_next       = PH_START;
            end
            OP_CLEAR:
            begin
                step_idx_next = '0;
                set_idx_next  = '0;
            end
            OP_UPDATE:
            begin
                phase_next = ph;
                unique case (ph)
                    PH_START:   phase_next = PH_FILL;
                    PH_FILL:    phase_next = PH_ACTUATE;
                    PH_ACTUATE: phase_next = PH_RUN;
                    PH_RUN:
                    begin
                        case (step_kind)
                            KIND_AGIT:
                            begin
                                if (step_done)
                                begin
                                    step_idx_next   = step_idx_reg + 1'b1;
                                    start_time_next = s1_now_reg;
                                    ccw_latch_next  = 1'b0;
                                end
                                else
                                begin
                                    ccw_latch_next = 1'b1;
                                end
                            end
                            KIND_SOAK:
                            begin
                                ccw_latch_next = 1'b0;
                                cw_latch_next  = !step_done;
                                if (step_done)
                                begin
                                    step_idx_next   = step_idx_reg + 1'b1;
                                    start_time_next = s1_now_reg;
                                end
                            end
                            KIND_END:
                            begin
                                step_idx_next = '0;
                                if (int'(set_idx_reg) < NUM_SETS - 1)
                                begin
                                    set_idx_next = set_idx_reg + 1'b1;
                                end
                                else
                                begin
                                    set_idx_next = '0;
                                    phase_next   = PH_END;
                                end
                            end
                            default: ;
                        endcase
                    end
                    PH_STOP:
                    begin
                        start_time_next = s1_now_reg;
                        ccw_latch_next  = 1'b0;
                        cw_latch_next   = 1'b0;
                        if (!s1_door_reg)
                        begin
                            phase_next = PH_START;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Sequencer state registers, loaded as each result is produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            step_idx_reg    <= '0;
            set_idx_reg     <= '0;
            program_idx_reg <= '0;
            start_time_reg  <= 32'd0;
            ccw_latch_reg   <= 1'b0;
            cw_latch_reg    <= 1'b0;
        end
        else if (s1_move && s1_valid_reg)
        begin
            phase_reg       <= phase_next;
            step_idx_reg    <= step_idx_next;
            set_idx_reg     <= set_idx_next;
            program_idx_reg <= program_idx_next;
            start_time_reg  <= start_time_next;
            ccw_latch_reg   <= ccw_latch_next;
            cw_latch_reg    <= cw_latch_next;
        end
    end

    // Result ports show the state left by the last word.
    assign out_valid   = out_valid_reg;
    assign motor_ccw   = ccw_latch_reg;
    assign motor_cw    = cw_latch_reg;
    assign phase       = phase_reg;
    assign step_number = 4'(step_idx_reg);
    assign set_number  = 2'(set_idx_reg);
    assign finished    = (phase_reg == PH_END);

    // The input side stalls only with a word waiting in the input register.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with an empty input register");

    // A stalled result keeps the sequencer state frozen.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(phase_reg) && $stable(step_idx_reg)
                                      && $stable(set_idx_reg) && $stable(start_time_reg)))
        else $error("sequencer state changed under a stalled result");

    // A word that leaves the input register always shows up as a result.
    a_word_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_move) |=> out_valid_reg)
        else $error("word left the input register without a result");

    // The step index never runs past the end-of-table position.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(step_idx_reg) <= NUM_STEPS)
        else $error("step index beyond the step table");

endmodule

[tb/sv/agss_result_checker.sv]
// Result checker for the agitate/soak step sequencer: tracks the sequencer state and compares words.
`timescale 1ns / 100ps
module agss_result_checker
    import agss_pkg::*;
#(
    parameter int NUM_SETS  = 3,
    parameter int NUM_STEPS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic        door_open,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        motor_ccw,
    input  logic        motor_cw,
    input  logic [3:0]  phase,
    input  logic [3:0]  step_number,
    input  logic [1:0]  set_number,
    input  logic        finished,
    output int          pending,
    output int          fails
);

    // One result word as the sequencer should present it.
    typedef struct packed {
        logic       ccw;
        logic       cw;
        phase_t     phase;
        logic [3:0] step_no;
        logic [1:0] set_no;
        logic       done;
    } motor_status_t;

    // Tracked sequencer state and the configuration it will take on the next start word.
    phase_t        cur_phase;
    logic [3:0]    cur_step;
    logic [1:0]    cur_set;
    logic          cur_prog;
    logic [31:0]   step_t0;
    logic          ccw_on;
    logic          cw_on;
    logic          cfg_prog;
    logic [1:0]    cfg_set;
    motor_status_t status_q[$];
    int            err_cnt;

    // Step table, the same for every program and set.
    function automatic step_kind_t kind_at(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd2: kind_at = KIND_SOAK;
            4'd1, 4'd3: kind_at = KIND_AGIT;
            default:    kind_at = KIND_END;
        endcase
    endfunction

    function automatic logic [15:0] duration_at(input logic [3:0] idx);
        case (idx)
            4'd0:    duration_at = 16'd1000;
            4'd1:    duration_at = 16'd500;
            4'd2:    duration_at = 16'd1000;
            4'd3:    duration_at = 16'd1500;
            4'd4:    duration_at = 16'd200;
            default: duration_at = 16'd0;
        endcase
    endfunction

    // One update in the run phase: act on the current step of the table.
    function automatic void run_current_step(input logic [31:0] tick);
        step_kind_t  kind;
        logic [15:0] dur;
        logic [31:0] elapsed;
        kind    = KIND_END;
        dur     = 16'd0;
        elapsed = tick - step_t0;
        if (cur_step < NUM_STEPS)
        begin
            kind = kind_at(cur_step);
            dur  = duration_at(cur_step);
        end
        case (kind)
            KIND_AGIT:
            begin
                if (elapsed >= {16'd0, dur})
                begin
                    cur_step = cur_step + 4'd1;
                    step_t0  = tick;
                    ccw_on   = 1'b0;
                end
                else
                begin
                    ccw_on = 1'b1;
                end
            end
            KIND_SOAK:
            begin
                ccw_on = 1'b0;
                cw_on  = 1'b1;
                if (elapsed >= {16'd0, dur})
                begin
                    cur_step = cur_step + 4'd1;
                    step_t0  = tick;
                    cw_on    = 1'b0;
                end
            end
            KIND_END:
            begin
                // End of a set: next set, or the whole program is done.
                if (cur_set < NUM_SETS - 1)
                begin
                    cur_set  = cur_set + 2'd1;
                    cur_step = 4'd0;
                end
                else
                begin
                    cur_phase = PH_END;
                    cur_step  = 4'd0;
                    cur_set   = 2'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // Apply one input word to the tracked state and return the word it should produce.
    function automatic motor_status_t advance_sequencer(input logic [1:0] op,
                                                        input logic [31:0] tick,
                                                        input logic door);
        motor_status_t r;
        if (op == OP_START)
        begin
            cur_prog  = cfg_prog;
            cur_set   = (cfg_set > NUM_SETS - 1) ? 2'(NUM_SETS - 1) : cfg_set;
            cur_phase = PH_START;
        end
        else if (op == OP_CLEAR)
        begin
            cur_step = 4'd0;
            cur_set  = 2'd0;
        end
        else if (op == OP_UPDATE)
        begin
            // An open door overrides whatever phase the sequencer is in.
            if (door)
                cur_phase = PH_STOP;
            case (cur_phase)
                PH_START:   cur_phase = PH_FILL;
                PH_FILL:    cur_phase = PH_ACTUATE;
                PH_ACTUATE: cur_phase = PH_RUN;
                PH_RUN:     run_current_step(tick);
                PH_STOP:
                begin
                    step_t0 = tick;
                    ccw_on  = 1'b0;
                    cw_on   = 1'b0;
                    if (!door)
                        cur_phase = PH_START;
                end
                default: ;
            endcase
        end
        r.ccw     = ccw_on;
        r.cw      = cw_on;
        r.phase   = cur_phase;
        r.step_no = cur_step;
        r.set_no  = cur_set;
        r.done    = (cur_phase == PH_END);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Follow both channels and the configuration port on every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        motor_status_t want;
        if (!rst_n)
        begin
            cur_phase = PH_IDLE;
            cur_step  = 4'd0;
            cur_set   = 2'd0;
            cur_prog  = 1'b0;
            step_t0   = 32'd0;
            ccw_on    = 1'b0;
            cw_on     = 1'b0;
            cfg_prog  = 1'b0;
            cfg_set   = 2'd0;
            status_q.delete();
            err_cnt   = 0;
            pending  <= 0;
            fails    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_PROGRAM_SELECT)
                    cfg_prog = cfg_data[0];
                else
                    cfg_set = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, phase %0d step %0d set %0d",
                             $time, phase, step_number, set_number);
                    err_cnt++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("motor_ccw", 32'(want.ccw), 32'(motor_ccw));
                    check_field("motor_cw", 32'(want.cw), 32'(motor_cw));
                    check_field("phase", 32'(want.phase), 32'(phase));
                    check_field("step_number", 32'(want.step_no), 32'(step_number));
                    check_field("set_number", 32'(want.set_no), 32'(set_number));
                    check_field("finished", 32'(want.done), 32'(finished));
                end
            end
            if (in_valid && !in_stall)
                status_q.push_back(advance_sequencer(opcode, now_ms, door_open));
            pending <= status_q.size();
            fails   <= err_cnt;
        end
    end

endmodule

[tb/sv/tb_agitate_soak_step_sequencer.sv]
// Testbench top for the agitate/soak step sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_agitate_soak_step_sequencer
    import agss_pkg::*;
();

    // The opcode that the block ignores.
    localparam logic [1:0] OP_IGNORED = 2'd3;
    // Longest quiet stretch is the receiver hold-off; allow far more.
    localparam int IDLE_LIMIT = 1000;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic [1:0]  opcode = 2'd0;
    logic [31:0] now_ms = 32'd0;
    logic        door_open = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        motor_ccw;
    logic        motor_cw;
    logic [3:0]  phase;
    logic [3:0]  step_number;
    logic [1:0]  set_number;
    logic        finished;
    int          pending;
    int          fails;

    // Sender and receiver bookkeeping.
    int          burst_left = 0;
    bit          steady = 1'b0;
    logic [31:0] tick_ms = 32'd0;
    int          hold_gen = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          mode_left = 0;
    int          quiet_cycles = 0;

    agitate_soak_step_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .now_ms      (now_ms),
        .door_open   (door_open),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .motor_ccw   (motor_ccw),
        .motor_cw    (motor_cw),
        .phase       (phase),
        .step_number (step_number),
        .set_number  (set_number),
        .finished    (finished)
    );

    agss_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .now_ms      (now_ms),
        .door_open   (door_open),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .motor_ccw   (motor_ccw),
        .motor_cw    (motor_cw),
        .phase       (phase),
        .step_number (step_number),
        .set_number  (set_number),
        .finished    (finished),
        .pending     (pending),
        .fails       (fails)
    );

    always #10 clk = ~clk;

    // Receiver: a long hold-off on request, otherwise a changing stall pattern.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ack != hold_gen)
        begin
            hold_ack  <= hold_gen;
            hold_left <= 79;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(10, 150);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
                RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                default:  out_stall <= (mode_left % 4 != 0);
            endcase
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb_agitate_soak_step_sequencer NOT OK");
                $finish;
            end
        end
    end

    // Offer one word and return at the edge that accepts it; gaps fall between bursts.
    task automatic send_word(input logic [1:0] op, input logic [31:0] tick, input logic door);
        if (!steady && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  <= 1'b1;
        opcode    <= op;
        now_ms    <= tick;
        door_open <= door;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers, program select first and then the start set, while the block is idle.
    task automatic set_config(input logic [1:0] prog_val, input logic [1:0] set_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PROGRAM_SELECT;
        cfg_data  <= prog_val;
        @(posedge clk);
        cfg_index <= CFG_START_SET;
        cfg_data  <= set_val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // A start word and a run of updates with a plausible tick, door openings and some noise.
    task automatic run_program(input int n_upd);
        int          k;
        int          door_left;
        int          pick;
        logic [31:0] step_ms;
        logic [1:0]  op;
        door_left = 0;
        if ($urandom_range(0, 3) == 0)
            tick_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
        else
            tick_ms = $urandom;
        send_word(OP_START, tick_ms, 1'($urandom_range(0, 1)));
        for (k = 0; k < n_upd; k++)
        begin
            // Tick advance: often exactly a step duration or one short of it.
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:    step_ms = (pick == 0) ? 32'd500 : 32'd1000;
                2:       step_ms = ($urandom_range(0, 1) != 0) ? 32'd1499 : 32'd199;
                3:       step_ms = 32'd0;
                4:       step_ms = ($urandom_range(0, 1) != 0) ? 32'd1500 : 32'd200;
                default: step_ms = $urandom_range(1, 900);
            endcase
            tick_ms = tick_ms + step_ms;
            if (door_left == 0 && $urandom_range(0, 29) == 0)
                door_left = $urandom_range(1, 3);
            pick = $urandom_range(0, 79);
            if (pick == 0)
                op = OP_CLEAR;
            else if (pick == 1)
                op = OP_IGNORED;
            else if (pick == 2)
                op = OP_START;
            else
                op = OP_UPDATE;
            send_word(op, tick_ms, door_left != 0);
            if (door_left != 0)
                door_left--;
        end
    endtask

    // Words with every field random.
    task automatic noise_items(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int ph;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle, ignored code, door stop and resume, timer wrap, exact step edges.
        send_word(OP_UPDATE, 32'h0000_0000, 1'b0);
        send_word(OP_IGNORED, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_UPDATE, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_UPDATE, 32'hFFFF_FF00, 1'b0);
        send_word(OP_CLEAR, 32'h0000_0000, 1'b1);
        send_word(OP_UPDATE, 32'h0000_0000, 1'b0);
        send_word(OP_UPDATE, 32'h0000_0000, 1'b0);
        send_word(OP_UPDATE, 32'h0000_0000, 1'b0);
        // Soak one short of its duration across the wrap, then exactly at it.
        send_word(OP_UPDATE, 32'h0000_02E7, 1'b0);
        send_word(OP_UPDATE, 32'h0000_02E8, 1'b0);
        // Agitate one short, then exactly at its duration.
        send_word(OP_UPDATE, 32'h0000_04DB, 1'b0);
        send_word(OP_UPDATE, 32'h0000_04DC, 1'b0);
        // Door opened in the run phase, held, then closed.
        send_word(OP_UPDATE, 32'h0000_04E6, 1'b1);
        send_word(OP_UPDATE, 32'h0000_0800, 1'b1);
        send_word(OP_UPDATE, 32'h0000_1000, 1'b0);
        send_word(OP_START, 32'h0000_0000, 1'b1);
        send_word(OP_UPDATE, 32'h0000_1000, 1'b0);
        send_word(OP_UPDATE, 32'h0000_1000, 1'b0);
        send_word(OP_UPDATE, 32'h0000_1000, 1'b0);
        send_word(OP_UPDATE, 32'h0000_13E8, 1'b0);
        // Tick one behind the timer: the elapsed time wraps to its maximum.
        send_word(OP_UPDATE, 32'h0000_13E7, 1'b0);
        send_word(OP_UPDATE, 32'h0000_2000, 1'b0);
        send_word(OP_UPDATE, 32'hAAAA_5555, 1'b0);
        send_word(OP_CLEAR, 32'h5555_AAAA, 1'b0);
        send_word(OP_UPDATE, 32'h5555_AAAA, 1'b1);

        // Random phases, each after the block has drained, with fresh settings.
        for (ph = 0; ph < 17; ph++)
        begin
            drain();
            case (ph)
                0:       set_config(2'd0, 2'd0);
                1:       set_config(2'd1, 2'd2);
                2:       set_config(2'd3, 2'd3);
                3:       set_config(2'd2, 2'd1);
                default: set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            endcase
            // One phase runs gapless against a long receiver hold-off.
            if (ph == 3)
            begin
                hold_gen <= hold_gen + 1;
                steady = 1'b1;
            end
            if (ph % 5 == 4)
                noise_items(30);
            else
                run_program(44);
            steady = 1'b0;
        end

        drain();
        if (fails == 0 && pending == 0)
            $display("tb_agitate_soak_step_sequencer OK");
        else
            $display("tb_agitate_soak_step_sequencer NOT OK");
        $finish;
    end

endmodule
